// ----- hw/rtl/fpba_pkg.sv -----
// Shared types, constants and lookup tables for the frame peak banded attenuation block.
package fpba_pkg;

    // Field widths and format of the pixel stream.
    localparam int PIXEL_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_BITS   = 24;

    // Band and gain tables.
    localparam int NUM_BANDS = 10;
    localparam int BAND_BITS = 4;
    localparam int GAIN_BITS = 10;
    localparam int PCT_BITS  = 7;
    localparam int CMP_BITS  = PIXEL_BITS + PCT_BITS;

    // Rounded division by 1000 after scaling by 2^FRAC_BITS.
    // (x * 2^8 + 500) / 1000 reduces to (x * 32 + 62) / 125, and the
    // division by 125 is a multiplication by a reciprocal.
    localparam int X_BITS     = PIXEL_BITS + GAIN_BITS;
    localparam int PRE_SHIFT  = FRAC_BITS - 3;
    localparam int Y_BITS     = X_BITS + PRE_SHIFT;
    localparam int ROUND_BIAS = 62;
    localparam int RECIP_BITS = 32;
    localparam int QUOT_SHIFT = 38;
    localparam int PROD_BITS  = Y_BITS + RECIP_BITS;
    localparam int QUOT_BITS  = PROD_BITS - QUOT_SHIFT;
    localparam logic [RECIP_BITS-1:0] RECIP_125 = 32'd2199023256;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [BAND_BITS-1:0]  band_t;
    typedef logic [GAIN_BITS-1:0]  gain_t;
    typedef logic [OUT_BITS-1:0]   out_t;

    // Band index for pixels that pass unchanged.
    localparam band_t BAND_PASS = 4'd10;

    typedef enum logic [1:0] {
        CMD_MEASURE = 2'd0,
        CMD_CORRECT = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    // Upper bound of each band as a percentage of the peak.
    function automatic logic [PCT_BITS-1:0] band_percent(input band_t idx);
        logic [PCT_BITS-1:0] pct;
        case (idx)
            4'd0:    pct = 7'd50;
            4'd1:    pct = 7'd55;
            4'd2:    pct = 7'd59;
            4'd3:    pct = 7'd63;
            4'd4:    pct = 7'd65;
            4'd5:    pct = 7'd66;
            4'd6:    pct = 7'd67;
            4'd7:    pct = 7'd68;
            4'd8:    pct = 7'd69;
            4'd9:    pct = 7'd70;
            default: pct = 7'd100;
        endcase
        return pct;
    endfunction

    // Gain of each band in thousandths.
    function automatic gain_t gain_milli(input band_t idx);
        gain_t g;
        case (idx)
            4'd0:    g = 10'd700;
            4'd1:    g = 10'd750;
            4'd2:    g = 10'd800;
            4'd3:    g = 10'd850;
            4'd4:    g = 10'd900;
            4'd5:    g = 10'd940;
            4'd6:    g = 10'd970;
            4'd7:    g = 10'd990;
            4'd8:    g = 10'd995;
            4'd9:    g = 10'd999;
            default: g = 10'd1000;
        endcase
        return g;
    endfunction

endpackage

// ----- hw/rtl/fpba_band_select.sv -----
// Band selection: compares a pixel with the ten percentage bounds of the peak.
module fpba_band_select (
    input  fpba_pkg::pixel_t pixel,
    input  fpba_pkg::pixel_t peak,
    output fpba_pkg::band_t  band,
    output fpba_pkg::gain_t  gain
);

    logic [fpba_pkg::CMP_BITS-1:0]  px_scaled;
    logic [fpba_pkg::NUM_BANDS-1:0] below;

    // Pixel times 100, compared against each bound times the peak.
    always_comb
    begin
        px_scaled = fpba_pkg::CMP_BITS'(pixel) * fpba_pkg::CMP_BITS'(100);
        for (int b = 0; b < fpba_pkg::NUM_BANDS; b++)
        begin
            below[b] = px_scaled <=
                (fpba_pkg::CMP_BITS'(fpba_pkg::band_percent(fpba_pkg::BAND_BITS'(b))) *
                 fpba_pkg::CMP_BITS'(peak));
        end
    end

    // The lowest bound that the pixel does not exceed picks the band.
    always_comb
    begin
        band = fpba_pkg::BAND_PASS;
        for (int b = fpba_pkg::NUM_BANDS - 1; b >= 0; b--)
        begin
            if (below[b])
            begin
                band = fpba_pkg::BAND_BITS'(b);
            end
        end
        gain = fpba_pkg::gain_milli(band);
    end

endmodule

// ----- hw/rtl/frame_peak_banded_attenuation.sv -----
// Top level: peak tracking and banded pixel attenuation with a three-stage pipeline.
// Correct requests pass the input, band stage and result registers to the output.
// One request per cycle unless out_stall; measure and clear requests give no output.
// The peak update happens in the band stage, so each request sees all earlier ones.
// The multiplications by the gain and by the reciprocal of 125 set the stage split.
// Reset clears the peak and all stage valid flags; payload registers are not reset.
module frame_peak_banded_attenuation (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [fpba_pkg::PIXEL_BITS-1:0] pixel,
    input  logic                          row_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fpba_pkg::OUT_BITS-1:0] corrected,
    output logic [fpba_pkg::BAND_BITS-1:0] band,
    output logic                          row_last
);

    // Input register.
    logic                   s0_valid_reg;
    fpba_pkg::cmd_t         s0_cmd_reg;
    fpba_pkg::pixel_t       s0_pixel_reg;
    logic                   s0_row_end_reg;

    // Band stage register.
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [fpba_pkg::X_BITS-1:0] s1_prod_reg;
    fpba_pkg::pixel_t       s1_pixel_reg;
    fpba_pkg::band_t        s1_band_reg;
    logic                   s1_row_end_reg;

    // Result register.
    logic                   out_valid_reg;
    fpba_pkg::out_t         corrected_reg;
    fpba_pkg::out_t         corrected_next;
    fpba_pkg::band_t        band_reg;
    logic                   row_last_reg;

    // Peak state.
    fpba_pkg::pixel_t       peak_reg;
    fpba_pkg::pixel_t       peak_next;

    logic                   s2_ready;
    logic                   s1_ready;
    logic                   s0_fire;

    fpba_pkg::band_t        sel_band;
    fpba_pkg::gain_t        sel_gain;

    logic [fpba_pkg::Y_BITS-1:0]    div_in;
    logic [fpba_pkg::PROD_BITS-1:0] div_prod;
    logic [fpba_pkg::QUOT_BITS-1:0] div_quot;
    fpba_pkg::out_t                 atten_val;
    fpba_pkg::out_t                 pass_val;

    // Pipeline flow control: a stage moves on when the next one is free.
    assign s2_ready = !out_valid_reg || !out_stall;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_fire  = s0_valid_reg && s1_ready;
    assign in_stall = s0_valid_reg && !s1_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s0_cmd_reg     <= fpba_pkg::cmd_t'(command);
            s0_pixel_reg   <= pixel;
            s0_row_end_reg <= row_end;
        end
    end

    // Band selection against the current peak.
    fpba_band_select u_band_select (
        .pixel (s0_pixel_reg),
        .peak  (peak_reg),
        .band  (sel_band),
        .gain  (sel_gain)
    );

    // Peak update for measure and clear requests.
    always_comb
    begin
        peak_next = peak_reg;
        if (s0_fire)
        begin
            case (s0_cmd_reg)
                fpba_pkg::CMD_MEASURE:
                begin
                    if (s0_pixel_reg > peak_reg)
                    begin
                        peak_next = s0_pixel_reg;
                    end
                end
                fpba_pkg::CMD_CLEAR:
                begin
                    peak_next = '0;
                end
                default:
                begin
                    peak_next = peak_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
        end
        else
        begin
            peak_reg <= peak_next;
        end
    end

    // Band stage: only correct requests go further.
    assign s1_valid_next = s0_fire && (s0_cmd_reg == fpba_pkg::CMD_CORRECT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s1_valid_next)
        begin
            s1_prod_reg    <= fpba_pkg::X_BITS'(s0_pixel_reg) * fpba_pkg::X_BITS'(sel_gain);
            s1_pixel_reg   <= s0_pixel_reg;
            s1_band_reg    <= sel_band;
            s1_row_end_reg <= s0_row_end_reg;
        end
    end

    // Rounded division by 1000 through the reciprocal of 125.
    always_comb
    begin
        div_in   = {s1_prod_reg, {fpba_pkg::PRE_SHIFT{1'b0}}} +
                   fpba_pkg::Y_BITS'(fpba_pkg::ROUND_BIAS);
        div_prod = fpba_pkg::PROD_BITS'(div_in) * fpba_pkg::PROD_BITS'(fpba_pkg::RECIP_125);
        div_quot = div_prod[fpba_pkg::PROD_BITS-1:fpba_pkg::QUOT_SHIFT];
        if (div_quot > fpba_pkg::QUOT_BITS'({fpba_pkg::OUT_BITS{1'b1}}))
        begin
            atten_val = {fpba_pkg::OUT_BITS{1'b1}};
        end
        else
        begin
            atten_val = div_quot[fpba_pkg::OUT_BITS-1:0];
        end
        pass_val = {s1_pixel_reg, {fpba_pkg::FRAC_BITS{1'b0}}};
        if (s1_band_reg == fpba_pkg::BAND_PASS)
        begin
            corrected_next = pass_val;
        end
        else
        begin
            corrected_next = atten_val;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            corrected_reg <= corrected_next;
            band_reg      <= s1_band_reg;
            row_last_reg  <= s1_row_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign corrected = corrected_reg;
    assign band      = band_reg;
    assign row_last  = row_last_reg;

endmodule
